// ===== hdl/bavg_pkg.sv =====
// Package for the block average decimator: shared constants, codes and payload types.
`default_nettype none

package bavg_pkg;

  // Fixed field widths
  localparam int SAMPLE_BITS = 32;
  localparam int CFG_W       = 13;
  localparam int WIN_CFG_W   = 5;
  localparam int CFG_IDX_W   = 2;

  // Default sizing of the top level
  localparam int MAX_COLS_DEF   = 4096;
  localparam int MAX_ROWS_DEF   = 4096;
  localparam int MAX_WINDOW_DEF = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_ROWS  = 2'd0,
    REG_IMAGE_COLS  = 2'd1,
    REG_WINDOW_SIZE = 2'd2
  } cfg_reg_t;

  // Input transaction payload
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          invalid;
  } bavg_in_t;

  // Result transaction payload
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] block_mean;
    logic                          row_last;
    logic                          frame_last;
  } bavg_out_t;

  // Position flags of the current pixel
  typedef struct packed {
    logic in_region;
    logic first;
    logic emit;
    logic row_last;
    logic frame_last;
  } bavg_pix_t;

  // Side information that rides along with a block sum through the divider
  typedef struct packed {
    logic bad;
    logic row_last;
    logic frame_last;
  } bavg_tag_t;

endpackage

`default_nettype wire

// ===== hdl/bavg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bavg_ram
  import bavg_pkg::*;
#(
  parameter int WIDTH = SAMPLE_BITS,
  parameter int DEPTH = MAX_COLS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/bavg_pos.sv =====
// Raster position tracker: pixel, window and block counters and their flags.
`default_nettype none

module bavg_pos
  import bavg_pkg::*;
#(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int COL_W  = $clog2(MAX_COLS + 1),
  localparam int ROW_W  = $clog2(MAX_ROWS + 1),
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1),
  localparam int ADDR_W = $clog2(MAX_COLS)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic              restart,
  input  wire logic [ROW_W-1:0]  rows,
  input  wire logic [COL_W-1:0]  cols,
  input  wire logic [WIN_W-1:0]  win,
  output      bavg_pix_t         pix,
  output      logic [ADDR_W-1:0] blk_addr
);

  localparam int RIDX_W = $clog2(MAX_ROWS);
  localparam int WIDX_W = $clog2(MAX_WINDOW);
  localparam int CS_W   = ((ADDR_W > WIN_W) ? ADDR_W : WIN_W) + 2;
  localparam int RS_W   = ((RIDX_W > WIN_W) ? RIDX_W : WIN_W) + 2;

  logic [ADDR_W-1:0] col_pos_r,       col_pos_nxt;
  logic [WIDX_W-1:0] col_in_win_r,    col_in_win_nxt;
  logic [ADDR_W-1:0] blk_col_r,       blk_col_nxt;
  logic [ADDR_W-1:0] blk_col_start_r, blk_col_start_nxt;
  logic [RIDX_W-1:0] row_pos_r,       row_pos_nxt;
  logic [WIDX_W-1:0] row_in_win_r,    row_in_win_nxt;
  logic [RIDX_W-1:0] blk_row_start_r, blk_row_start_nxt;

  logic [CS_W-1:0]   col_fit_end, col_next_end, col_start_adv;
  logic [RS_W-1:0]   row_fit_end, row_next_end, row_start_adv;
  logic              col_fits, row_fits, col_blk_last, row_blk_last;
  logic              col_at_end, row_at_end;
  logic [COL_W-1:0]  col_pos_inc;
  logic [ROW_W-1:0]  row_pos_inc;
  logic [WIN_W-1:0]  col_win_inc, row_win_inc, win_m1;

  // Block extent checks against the image edges
  always_comb begin
    win_m1        = win - WIN_W'(1);
    col_fit_end   = CS_W'(blk_col_start_r) + CS_W'(win);
    col_next_end  = CS_W'(blk_col_start_r) + CS_W'({win, 1'b0});
    col_start_adv = col_fit_end;
    row_fit_end   = RS_W'(blk_row_start_r) + RS_W'(win);
    row_next_end  = RS_W'(blk_row_start_r) + RS_W'({win, 1'b0});
    row_start_adv = row_fit_end;
    col_fits      = col_fit_end <= CS_W'(cols);
    row_fits      = row_fit_end <= RS_W'(rows);
    col_blk_last  = col_next_end > CS_W'(cols);
    row_blk_last  = row_next_end > RS_W'(rows);
    col_at_end    = WIN_W'(col_in_win_r) == win_m1;
    row_at_end    = WIN_W'(row_in_win_r) == win_m1;
  end

  // Flags of the pixel at the current position
  always_comb begin
    pix.in_region  = col_fits && row_fits;
    pix.first      = (col_in_win_r == '0) && (row_in_win_r == '0);
    pix.emit       = col_fits && row_fits && col_at_end && row_at_end;
    pix.row_last   = col_blk_last;
    pix.frame_last = col_blk_last && row_blk_last;
    blk_addr       = blk_col_r;
  end

  // Advance the position by one pixel in raster order
  always_comb begin
    col_pos_nxt       = col_pos_r;
    col_in_win_nxt    = col_in_win_r;
    blk_col_nxt       = blk_col_r;
    blk_col_start_nxt = blk_col_start_r;
    row_pos_nxt       = row_pos_r;
    row_in_win_nxt    = row_in_win_r;
    blk_row_start_nxt = blk_row_start_r;
    col_pos_inc       = COL_W'(col_pos_r) + COL_W'(1);
    row_pos_inc       = ROW_W'(row_pos_r) + ROW_W'(1);
    col_win_inc       = WIN_W'(col_in_win_r) + WIN_W'(1);
    row_win_inc       = WIN_W'(row_in_win_r) + WIN_W'(1);
    if (step) begin
      col_pos_nxt    = col_pos_inc[ADDR_W-1:0];
      col_in_win_nxt = col_win_inc[WIDX_W-1:0];
      if (col_win_inc >= win) begin
        col_in_win_nxt    = '0;
        blk_col_nxt       = blk_col_r + ADDR_W'(1);
        blk_col_start_nxt = col_start_adv[ADDR_W-1:0];
      end
      if (col_pos_inc >= cols) begin
        col_pos_nxt       = '0;
        col_in_win_nxt    = '0;
        blk_col_nxt       = '0;
        blk_col_start_nxt = '0;
        row_pos_nxt       = row_pos_inc[RIDX_W-1:0];
        row_in_win_nxt    = row_win_inc[WIDX_W-1:0];
        if (row_win_inc >= win) begin
          row_in_win_nxt    = '0;
          blk_row_start_nxt = row_start_adv[RIDX_W-1:0];
        end
        if (row_pos_inc >= rows) begin
          row_pos_nxt       = '0;
          row_in_win_nxt    = '0;
          blk_row_start_nxt = '0;
        end
      end
    end
  end

  // Position registers; a configuration write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_pos_r       <= '0;
      col_in_win_r    <= '0;
      blk_col_r       <= '0;
      blk_col_start_r <= '0;
      row_pos_r       <= '0;
      row_in_win_r    <= '0;
      blk_row_start_r <= '0;
    end else begin
      col_pos_r       <= col_pos_nxt;
      col_in_win_r    <= col_in_win_nxt;
      blk_col_r       <= blk_col_nxt;
      blk_col_start_r <= blk_col_start_nxt;
      row_pos_r       <= row_pos_nxt;
      row_in_win_r    <= row_in_win_nxt;
      blk_row_start_r <= blk_row_start_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/bavg_div.sv =====
// Bit-serial signed divider that turns a block sum into a mean truncated toward zero.
`default_nettype none

module bavg_div
  import bavg_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int SUM_W = SAMPLE_BITS + 2 * $clog2(MAX_WINDOW),
  localparam int DVS_W = 2 * $clog2(MAX_WINDOW + 1)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [SUM_W-1:0] dividend,
  input  wire logic [DVS_W-1:0]        divisor,
  input  wire bavg_tag_t               tag,
  output      logic                    idle,
  output      logic                    res_valid,
  input  wire logic                    res_ready,
  output      bavg_out_t               res
);

  localparam int CNT_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

  div_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic             neg_r;
  bavg_tag_t        tag_r;

  logic [DVS_W:0]   trial, diff;
  logic             ge;
  logic [SUM_W-1:0] q_signed;

  // One quotient bit per cycle: shift in the next dividend bit, try to subtract
  always_comb begin
    trial   = {rem_r, quo_r[SUM_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    quo_nxt = {quo_r[SUM_W-2:0], ge};
    cnt_nxt = cnt_r - CNT_W'(1);
  end

  // Sequence idle, run and hold-result
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DIV_IDLE: if (start) state_nxt = DIV_RUN;
      DIV_RUN:  if (cnt_r == '0) state_nxt = DIV_DONE;
      DIV_DONE: if (res_ready) state_nxt = DIV_IDLE;
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Load the magnitude on start, then iterate
  always_ff @(posedge clk) begin
    if (state_r == DIV_IDLE && start) begin
      neg_r <= dividend[SUM_W-1];
      quo_r <= dividend[SUM_W-1] ? (SUM_W'(0) - dividend) : dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      tag_r <= tag;
      cnt_r <= CNT_W'(SUM_W - 1);
    end else if (state_r == DIV_RUN) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Restore the sign and zero a block that held an invalid pixel
  always_comb begin
    q_signed       = neg_r ? (SUM_W'(0) - quo_r) : quo_r;
    res.block_mean = tag_r.bad ? '0 : q_signed[SAMPLE_BITS-1:0];
    res.row_last   = tag_r.row_last;
    res.frame_last = tag_r.frame_last;
    idle           = state_r == DIV_IDLE;
    res_valid      = state_r == DIV_DONE;
  end

`ifndef SYNTH
  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == DIV_IDLE)
    else $error("divider started while busy");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == DIV_RUN |-> rem_r < dvs_r)
    else $error("partial remainder not below divisor");

  a_run_to_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == DIV_RUN && cnt_r == '0 |=> state_r == DIV_DONE)
    else $error("divider missed its last step");
`endif

endmodule

`default_nettype wire

// ===== hdl/block_average_decimator_unit.sv =====
// Top level of the block average decimator: configuration, column-sum update and result register.
`default_nettype none

// Pixels arrive in raster order and are summed per block column in a RAM of
// MAX_COLS entries (a sum and a bad mark each). Each accepted pixel reads its
// entry, and the updated sum is written back in the next cycle; back-to-back
// pixels of the same block column take the new value from a bypass register,
// so the input takes one pixel per clock while no block sum is being handed to
// or held in the divider. A pixel that completes a block hands the sum to a
// bit-serial divider, one quotient bit per cycle, and input stays blocked
// until the divide is done and the result has moved to the output register.
// One finished result can wait in the output register while pixels of the
// next block keep flowing; a second finished block holds the divider, and
// with it the input, until the first result is taken. A configuration write
// to the rows, columns or window register restarts the frame at pixel (0,0);
// registers are clamped to 1..maximum.
module block_average_decimator_unit
  import bavg_pkg::*;
#(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire bavg_in_t             in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      bavg_out_t            out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int COL_W  = $clog2(MAX_COLS + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int ADDR_W = $clog2(MAX_COLS);
  localparam int SUM_W  = SAMPLE_BITS + 2 * $clog2(MAX_WINDOW);
  localparam int DVS_W  = 2 * WIN_W;
  localparam int WORD_W = SUM_W + 1;

  logic [ROW_W-1:0]  rows_r, rows_nxt;
  logic [COL_W-1:0]  cols_r, cols_nxt;
  logic [WIN_W-1:0]  win_r, win_nxt;
  logic              restart;

  bavg_pix_t         pix;
  logic [ADDR_W-1:0] pix_addr;
  logic              in_fire;

  logic                          s1_valid_r;
  bavg_pix_t                     s1_flags_r;
  logic [ADDR_W-1:0]             s1_addr_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          s1_bad_r;
  logic                          s1_fwd_r;
  logic [WORD_W-1:0]             fwd_word_r;
  logic                          s1_fwd_nxt;

  logic                    ram_we;
  logic [WORD_W-1:0]       ram_wdata, ram_rdata, old_word;
  logic signed [SUM_W-1:0] sample_ext, new_sum;
  logic                    new_bad;

  logic             div_start, div_idle, div_res_valid, div_take;
  logic [DVS_W-1:0] win_sq;
  bavg_tag_t        div_tag;
  bavg_out_t        div_res;

  logic      out_valid_r;
  bavg_out_t out_data_r;

  // Clamp register writes into their legal ranges
  always_comb begin
    rows_nxt = rows_r;
    cols_nxt = cols_r;
    win_nxt  = win_r;
    restart  = 1'b0;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_ROWS: begin
          restart = 1'b1;
          if (cfg_data == '0) rows_nxt = ROW_W'(1);
          else if (cfg_data > MAX_ROWS) rows_nxt = ROW_W'(MAX_ROWS);
          else rows_nxt = ROW_W'(cfg_data);
        end
        REG_IMAGE_COLS: begin
          restart = 1'b1;
          if (cfg_data == '0) cols_nxt = COL_W'(1);
          else if (cfg_data > MAX_COLS) cols_nxt = COL_W'(MAX_COLS);
          else cols_nxt = COL_W'(cfg_data);
        end
        REG_WINDOW_SIZE: begin
          restart = 1'b1;
          if (cfg_data[WIN_CFG_W-1:0] == '0) win_nxt = WIN_W'(1);
          else if (cfg_data[WIN_CFG_W-1:0] > MAX_WINDOW) win_nxt = WIN_W'(MAX_WINDOW);
          else win_nxt = WIN_W'(cfg_data[WIN_CFG_W-1:0]);
        end
        default: restart = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= ROW_W'(1);
      cols_r <= COL_W'(1);
      win_r  <= WIN_W'(1);
    end else begin
      rows_r <= rows_nxt;
      cols_r <= cols_nxt;
      win_r  <= win_nxt;
    end
  end

  // Track the raster position
  bavg_pos #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_fire),
    .restart  (restart),
    .rows     (rows_r),
    .cols     (cols_r),
    .win      (win_r),
    .pix      (pix),
    .blk_addr (pix_addr)
  );

  // Hold input while a block sum is handed to the divider, divided, or waiting to be taken
  assign div_start = s1_valid_r && s1_flags_r.emit;
  assign in_ready  = div_idle && !div_start;
  assign in_fire   = in_valid && in_ready;

  // Bypass when the entry read now is the one being written now
  assign s1_fwd_nxt = s1_valid_r && s1_flags_r.in_region && (s1_addr_r == pix_addr);

  // Read stage: capture the pixel while its column entry is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_flags_r  <= pix;
      s1_addr_r   <= pix_addr;
      s1_sample_r <= in_data.sample;
      s1_bad_r    <= in_data.invalid;
      s1_fwd_r    <= s1_fwd_nxt;
      fwd_word_r  <= ram_wdata;
    end
  end

  // Column sum and bad mark store
  bavg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_COLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr_r),
    .wdata (ram_wdata),
    .re    (in_fire && pix.in_region),
    .raddr (pix_addr),
    .rdata (ram_rdata)
  );

  // Modify stage: the first pixel of a block overwrites, the rest accumulate
  always_comb begin
    old_word   = s1_fwd_r ? fwd_word_r : ram_rdata;
    sample_ext = {{(SUM_W - SAMPLE_BITS){s1_sample_r[SAMPLE_BITS-1]}}, s1_sample_r};
    if (s1_flags_r.first) begin
      new_sum = sample_ext;
      new_bad = s1_bad_r;
    end else begin
      new_sum = $signed(old_word[SUM_W-1:0]) + sample_ext;
      new_bad = old_word[SUM_W] || s1_bad_r;
    end
    ram_wdata = {new_bad, new_sum};
    ram_we    = s1_valid_r && s1_flags_r.in_region;
  end

  // Divide the finished block sum by the window area
  always_comb begin
    win_sq             = DVS_W'(win_r) * DVS_W'(win_r);
    div_tag.bad        = new_bad;
    div_tag.row_last   = s1_flags_r.row_last;
    div_tag.frame_last = s1_flags_r.frame_last;
  end

  bavg_div #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (new_sum),
    .divisor   (win_sq),
    .tag       (div_tag),
    .idle      (div_idle),
    .res_valid (div_res_valid),
    .res_ready (div_take),
    .res       (div_res)
  );

  // Output register: load a new result when empty or being drained
  assign div_take = div_res_valid && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_take) begin
      out_data_r <= div_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_div_free_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> div_idle)
    else $error("block finished while divider busy");

  a_div_busy_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_idle)
    else $error("divider did not take the block sum");

  a_fwd_matches_write: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_fwd_r |-> $past(ram_we) && $past(s1_addr_r) == s1_addr_r)
    else $error("bypass used without a write to the same entry");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_block_average_decimator_unit.sv =====
// Testbench for the block average decimator: raster pixel stimulus, block-mean prediction and checks.
`default_nettype none

module tb_block_average_decimator_unit
  import bavg_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 960;
  localparam int unsigned QUIET_ITEMS  = 250;
  localparam int unsigned LONG_HOLD    = 300;
  // Index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Block-mean predictor and store of expected block results
  class block_mean_scoreboard;
    logic [CFG_W-1:0]     rows_reg;
    logic [CFG_W-1:0]     cols_reg;
    logic [WIN_CFG_W-1:0] win_reg;
    int unsigned px_col, px_row, win_row, win_col, blk_col;
    longint      col_sum [MAX_COLS_DEF];
    bit          col_bad [MAX_COLS_DEF];
    bavg_out_t   expected_blocks [$];
    int          errors;

    function new();
      rows_reg = 1;
      cols_reg = 1;
      win_reg  = 1;
      errors   = 0;
      restart();
    endfunction

    function void restart();
      px_col  = 0;
      px_row  = 0;
      win_row = 0;
      win_col = 0;
      blk_col = 0;
    endfunction

    // Zero acts as one, anything above the maximum acts as the maximum
    function int unsigned eff_size(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_IMAGE_ROWS:  rows_reg = val;
        REG_IMAGE_COLS:  cols_reg = val;
        REG_WINDOW_SIZE: win_reg  = val[WIN_CFG_W-1:0];
        default:         return;
      endcase
      restart();
    endfunction

    function int pending();
      return expected_blocks.size();
    endfunction

    // Accumulate one accepted pixel; queue a block mean when its block completes
    function void note_pixel(bavg_in_t px);
      int unsigned rows, cols, w, bcols, brows;
      longint      mean;
      bavg_out_t   res;
      rows  = eff_size(rows_reg, MAX_ROWS_DEF);
      cols  = eff_size(cols_reg, MAX_COLS_DEF);
      w     = eff_size(win_reg, MAX_WINDOW_DEF);
      bcols = cols / w;
      brows = rows / w;
      if (px_col < bcols * w && px_row < brows * w) begin
        if (win_row == 0 && win_col == 0) begin
          col_sum[blk_col] = longint'($signed(px.sample));
          col_bad[blk_col] = px.invalid;
        end else begin
          col_sum[blk_col] += longint'($signed(px.sample));
          if (px.invalid) col_bad[blk_col] = 1'b1;
        end
        if (win_row == w - 1 && win_col == w - 1) begin
          mean = col_sum[blk_col] / longint'(w * w);
          if (col_bad[blk_col]) mean = 0;
          res.block_mean = mean[SAMPLE_BITS-1:0];
          res.row_last   = (blk_col == bcols - 1);
          res.frame_last = (blk_col == bcols - 1) && (px_row == brows * w - 1);
          expected_blocks.push_back(res);
        end
      end
      // Advance the raster position
      px_col++;
      win_col++;
      if (win_col >= w) begin
        win_col = 0;
        blk_col++;
      end
      if (px_col >= cols) begin
        px_col  = 0;
        win_col = 0;
        blk_col = 0;
        px_row++;
        win_row++;
        if (win_row >= w) win_row = 0;
        if (px_row >= rows) begin
          px_row  = 0;
          win_row = 0;
        end
      end
    endfunction

    function void check_block(bavg_out_t got);
      bavg_out_t want;
      if (expected_blocks.size() == 0) begin
        $error("unexpected block result: block_mean %0d", got.block_mean);
        errors++;
        return;
      end
      want = expected_blocks.pop_front();
      if (got.block_mean !== want.block_mean) begin
        $error("block_mean: expected %0d, got %0d", want.block_mean, got.block_mean);
        errors++;
      end
      if (got.row_last !== want.row_last) begin
        $error("row_last: expected %0b, got %0b", want.row_last, got.row_last);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  bavg_in_t             in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  bavg_out_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  block_mean_scoreboard sb = new();

  bit          src_idle_on  = 1'b1;
  bit          sink_idle_on = 1'b1;
  bit          sink_hold_req = 1'b0;
  int unsigned sink_stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;

  block_average_decimator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_pixel(in_data);
      if (out_valid && out_ready) sb.check_block(out_data);
    end
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  always @(negedge clk) begin
    if (sink_stall_left > 0) begin
      out_ready <= 1'b0;
      sink_stall_left--;
    end else if (sink_hold_req) begin
      sink_hold_req = 1'b0;
      out_ready <= 1'b0;
      sink_stall_left = LONG_HOLD - 1;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      sink_stall_left = $urandom_range(1, 8) - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic bavg_in_t make_pixel(int unsigned bad_odds);
    bavg_in_t px;
    case ($urandom_range(0, 7))
      0:       px.sample = 32'h7FFF_FFFF;
      1:       px.sample = 32'h8000_0000;
      2, 3:    px.sample = 32'($urandom_range(0, 131071)) - 32'd65536;
      default: px.sample = $urandom;
    endcase
    px.invalid = (bad_odds != 0) && ($urandom_range(1, bad_odds) == 1);
    return px;
  endfunction

  // Offer one pixel, with an optional idle burst first; return at the falling edge
  task automatic send_pixel(bavg_in_t px);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_sample(logic [SAMPLE_BITS-1:0] value, logic bad);
    bavg_in_t px;
    px.sample  = value;
    px.invalid = bad;
    send_pixel(px);
  endtask

  task automatic send_random(int unsigned n, int unsigned bad_odds);
    repeat (n) send_pixel(make_pixel(bad_odds));
  endtask

  // Drop valid and hold until every expected block has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic settle();
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One register write; the caller owns cfg_we
  task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic configure(logic [CFG_W-1:0] rows, logic [CFG_W-1:0] cols,
                           logic [WIN_CFG_W-1:0] win);
    settle();
    cfg_we <= 1'b1;
    write_one(REG_IMAGE_ROWS, rows);
    write_one(REG_IMAGE_COLS, cols);
    write_one(REG_WINDOW_SIZE, CFG_W'(win));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One random configuration and a run of frames, sometimes ending mid-frame
  task automatic random_phase();
    int unsigned pick, w, rows, cols, frames, n, bad_odds;
    logic [CFG_W-1:0]     rows_code, cols_code;
    logic [WIN_CFG_W-1:0] win_code;
    pick = $urandom_range(0, 19);
    if (pick < 12)      w = $urandom_range(1, 4);
    else if (pick < 19) w = $urandom_range(5, 8);
    else                w = $urandom_range(9, 16);
    if (w > 8) begin
      rows = w + $urandom_range(0, 2);
      cols = w * $urandom_range(1, 2) + $urandom_range(0, 3);
    end else begin
      rows = w * $urandom_range(1, 3) + $urandom_range(0, w - 1);
      cols = w * $urandom_range(1, 3) + $urandom_range(0, w - 1);
    end
    // Now and then an image at most one block high
    if ($urandom_range(0, 9) == 0) rows = $urandom_range(1, w);
    case ($urandom_range(0, 3))
      0:       bad_odds = 0;
      1:       bad_odds = 4;
      2:       bad_odds = 32;
      default: bad_odds = 8 * w * w;
    endcase
    // Exercise the out-of-range encodings of the same sizes
    rows_code = rows;
    cols_code = cols;
    win_code  = w;
    if (rows == 1 && $urandom_range(0, 1) == 1) rows_code = 0;
    if (cols == 1 && $urandom_range(0, 1) == 1) cols_code = 0;
    if (w == 1 && $urandom_range(0, 1) == 1) win_code = 0;
    if (w == 16 && $urandom_range(0, 1) == 1) win_code = $urandom_range(17, 31);
    frames = (rows * cols > 300) ? 1 : $urandom_range(1, 3);
    n = frames * rows * cols;
    if ($urandom_range(0, 2) == 0) n += $urandom_range(0, rows * cols - 1);
    src_idle_on = sink_idle_on && ($urandom_range(0, 3) != 0);
    configure(rows_code, cols_code, win_code);
    send_random(n, bad_odds);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset sizes: every pixel is its own block, last in row and frame
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0005, 1'b1);

    // Negative sum truncates toward zero: -5 / 4 gives -1
    configure(2, 2, 2);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFE, 1'b0);

    // Write to the unused index leaves sizes and position alone
    settle();
    cfg_we <= 1'b1;
    write_one(REG_UNUSED, 13'h1FFF);
    cfg_we <= 1'b0;
    @(negedge clk);

    // Window larger than the image: nothing comes out
    configure(2, 2, 3);
    send_random(4, 0);

    // Zero sizes act as one
    configure(0, 0, 0);
    send_sample(32'h1234_5678, 1'b0);
    send_sample(32'h8765_4321, 1'b1);

    // Trailing row and column beyond the last whole block are dropped
    configure(3, 3, 2);
    send_random(9, 0);

    // Largest window with full-scale sums, window code above the maximum
    configure(16, 16, 31);
    repeat (256) send_sample(32'h7FFF_FFFF, 1'b0);
    repeat (256) send_sample(32'h8000_0000, 1'b0);

    // Oversized rows and columns clamp to the maximum
    configure(13'h1FFF, 13'h1FFF, 16);
    send_random(48, 0);
    configure(1, 4096, 1);
    send_random(200, 16);
    configure(13'h1FFF, 2, 2);
    send_random(40, 16);

    // Hold results off long enough to back up the input
    configure(4, 8, 1);
    sink_hold_req = 1'b1;
    send_random(32, 8);
    drain_results();
    send_random(32, 8);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= RANDOM_ITEMS - QUIET_ITEMS) sink_idle_on = 1'b0;
      random_phase();
      if (items_sent >= RANDOM_ITEMS - QUIET_ITEMS) src_idle_on = 1'b0;
    end

    settle();
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
